// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the accumulator execute block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ACPU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define ACPU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/acpu_pkg.sv -----
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared constants, instruction codes and queue item types of the
// accumulator execute block.
// ----------------------------------------------------------------------------
package acpu_pkg;

  // Default data memory depth.
  localparam int unsigned DATA_DEPTH_DEFAULT = 256;
  // Quotient of an 8-bit address by a depth of at least 16 fits in 4 bits.
  localparam int unsigned QUOT_W = 4;
  // Entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  // Program length after reset.
  localparam logic [8:0] PROG_LEN_RESET = 9'd256;

  // Instruction codes.
  localparam logic [3:0] CMD_NOP     = 4'd0;
  localparam logic [3:0] CMD_LDA_IMM = 4'd1;
  localparam logic [3:0] CMD_LDA_MEM = 4'd2;
  localparam logic [3:0] CMD_STA     = 4'd3;
  localparam logic [3:0] CMD_ADD_IMM = 4'd4;
  localparam logic [3:0] CMD_ADD_MEM = 4'd5;
  localparam logic [3:0] CMD_SUB_IMM = 4'd6;
  localparam logic [3:0] CMD_SUB_MEM = 4'd7;
  localparam logic [3:0] CMD_JMP     = 4'd8;
  localparam logic [3:0] CMD_BRZ     = 4'd9;
  localparam logic [3:0] CMD_BRC     = 4'd10;
  localparam logic [3:0] CMD_BRN     = 4'd11;
  localparam logic [3:0] CMD_END     = 4'd12;
  localparam logic [3:0] CMD_HOST_WR = 4'd13;

  // Instruction class as decoded by the front.
  typedef enum logic [3:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_STORE,
    KIND_ADD,
    KIND_SUB,
    KIND_JUMP,
    KIND_BRANCH,
    KIND_END,
    KIND_HOST,
    KIND_ILLEGAL
  } kind_e;

  // Flag tested by a branch.
  typedef enum logic [1:0] {
    COND_ZERO,
    COND_CARRY,
    COND_NEG
  } cond_e;

  // Decoded instruction held in the queue.
  typedef struct packed {
    kind_e             kind;
    logic              use_mem;
    cond_e             cond;
    logic [7:0]        operand;
    logic [7:0]        host_data;
    logic [QUOT_W-1:0] quot;
  } acpu_item_t;

  // Queue head as seen by the back.
  typedef struct packed {
    logic       valid;
    acpu_item_t item;
  } acpu_head_t;

endpackage

// ----- design/accumulator_cpu_execute.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_execute: 8-bit accumulator machine, one instruction per item
// Memory read at issue, then execute once the result register is free.
// A new item issues only after the previous one has executed.
// Reset clears queue, registers, flags and pointer; program length to 256.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute
  import acpu_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [3:0] command_i,
  input  logic [7:0] operand_i,
  input  logic [7:0] host_data_i,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] accumulator_out_o,
  output logic       zero_flag_o,
  output logic       carry_flag_o,
  output logic       negative_flag_o,
  output logic [7:0] next_pointer_o,
  output logic       target_in_range_o,
  output logic [7:0] memory_byte_o,
  output logic       halted_o
);

  acpu_head_t head;
  logic       head_pop;

  // Decode and queue incoming transfers.
  acpu_front #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .command_i  (command_i),
    .operand_i  (operand_i),
    .host_data_i(host_data_i),
    .head_o     (head),
    .pop_i      (head_pop)
  );

  // Execute and deliver results.
  acpu_back #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (head_pop),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .res_pop_i        (pop),
    .res_empty_o      (empty),
    .accumulator_out_o(accumulator_out_o),
    .zero_flag_o      (zero_flag_o),
    .carry_flag_o     (carry_flag_o),
    .negative_flag_o  (negative_flag_o),
    .next_pointer_o   (next_pointer_o),
    .target_in_range_o(target_in_range_o),
    .memory_byte_o    (memory_byte_o),
    .halted_o         (halted_o)
  );

endmodule

// ----- design/acpu_front.sv -----
// ----------------------------------------------------------------------------
// acpu_front
// Accepts instructions, classifies them and holds them in a short queue
// for the execute back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acpu_front
  import acpu_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [3:0] command_i,
  input  logic [7:0] operand_i,
  input  logic [7:0] host_data_i,
  output acpu_head_t head_o,
  input  logic       pop_i
);

  // Reciprocal of the depth, exact for 8-bit addresses.
  localparam int unsigned RECIP = (65536 + DATA_DEPTH - 1) / DATA_DEPTH;
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  acpu_item_t       item_d;
  logic [24:0]      quot_prod;
  acpu_item_t       queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;

  // Quotient of the address by the depth, for the back's index.
  assign quot_prod = 25'(operand_i) * 25'(RECIP);

  // Classify the incoming instruction.
  always_comb begin
    item_d           = '0;
    item_d.kind      = KIND_ILLEGAL;
    item_d.use_mem   = 1'b0;
    item_d.cond      = COND_ZERO;
    item_d.operand   = operand_i;
    item_d.host_data = host_data_i;
    item_d.quot      = quot_prod[16 +: QUOT_W];
    unique case (command_i)
      CMD_NOP:     item_d.kind = KIND_NOP;
      CMD_LDA_IMM: item_d.kind = KIND_LOAD;
      CMD_LDA_MEM: begin
        item_d.kind    = KIND_LOAD;
        item_d.use_mem = 1'b1;
      end
      CMD_STA:     item_d.kind = KIND_STORE;
      CMD_ADD_IMM: item_d.kind = KIND_ADD;
      CMD_ADD_MEM: begin
        item_d.kind    = KIND_ADD;
        item_d.use_mem = 1'b1;
      end
      CMD_SUB_IMM: item_d.kind = KIND_SUB;
      CMD_SUB_MEM: begin
        item_d.kind    = KIND_SUB;
        item_d.use_mem = 1'b1;
      end
      CMD_JMP:     item_d.kind = KIND_JUMP;
      CMD_BRZ: begin
        item_d.kind = KIND_BRANCH;
        item_d.cond = COND_ZERO;
      end
      CMD_BRC: begin
        item_d.kind = KIND_BRANCH;
        item_d.cond = COND_CARRY;
      end
      CMD_BRN: begin
        item_d.kind = KIND_BRANCH;
        item_d.cond = COND_NEG;
      end
      CMD_END:     item_d.kind = KIND_END;
      CMD_HOST_WR: item_d.kind = KIND_HOST;
      default:     item_d.kind = KIND_ILLEGAL;
    endcase
  end

  // Queue control.
  assign full_o      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign accept      = push_i && !full_o;
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (accept && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!accept && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the transfer in the queue.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= item_d;
    end
  end

  `ACPU_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ACPU_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, head_o.valid, "pop of empty queue")
  `ACPU_ASSERT(a_count_grows, clk_i, rst_ni, (accept && !pop_i) |=> (count_q == $past(count_q) + CNT_W'(1)), "queue count lost a transfer")

endmodule

// ----- design/acpu_back.sv -----
// ----------------------------------------------------------------------------
// acpu_back
// Executes queued instructions against the accumulator, flags, pointer and
// data memory, and holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acpu_back
  import acpu_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  acpu_head_t head_i,
  output logic       pop_o,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       res_pop_i,
  output logic       res_empty_o,
  output logic [7:0] accumulator_out_o,
  output logic       zero_flag_o,
  output logic       carry_flag_o,
  output logic       negative_flag_o,
  output logic [7:0] next_pointer_o,
  output logic       target_in_range_o,
  output logic [7:0] memory_byte_o,
  output logic       halted_o
);

  localparam int unsigned IDX_W = $clog2(DATA_DEPTH);

  // Sequencer states.
  localparam logic ST_ISSUE = 1'b0;
  localparam logic ST_EXEC  = 1'b1;

  typedef struct packed {
    logic [7:0] acc;
    logic       zero;
    logic       carry;
    logic       neg;
    logic [7:0] ptr;
    logic       in_range;
    logic [7:0] mbyte;
    logic       halted;
  } result_t;

  function automatic logic [2:0] flags_of(input logic [8:0] r);
    return {(r == 9'd0), r[8], r[7]};
  endfunction

  logic             state_q, state_d;
  logic             exec_go;
  logic [11:0]      idx_base;
  logic [11:0]      idx_rem;
  logic [IDX_W-1:0] rd_idx;
  acpu_item_t       ex_item_q;
  logic [IDX_W-1:0] ex_idx_q;
  logic [7:0]       dmem [DATA_DEPTH];
  logic [7:0]       rdata_q;
  logic             mem_we;
  logic [7:0]       mem_wdata;

  logic [7:0] acc_q, acc_d;
  logic       zero_q, zero_d;
  logic       carry_q, carry_d;
  logic       neg_q, neg_d;
  logic [7:0] ip_q, ip_d;
  logic       halt_q, halt_d;
  logic [8:0] prog_len_q;
  logic       res_valid_q;
  result_t    res_q, res_d;

  logic [7:0] src;
  logic [8:0] alu;
  logic       cond;
  logic [7:0] mbyte;
  logic       in_range;

  // Reduce the address modulo the depth from the precomputed quotient.
  assign idx_base = 12'(head_i.item.quot) * 12'(DATA_DEPTH);
  assign idx_rem  = 12'(head_i.item.operand) - idx_base;
  assign rd_idx   = idx_rem[IDX_W-1:0];

  // Issue one item, then execute it once the memory byte is back and the result register is free.
  assign pop_o   = (state_q == ST_ISSUE) && head_i.valid;
  assign exec_go = (state_q == ST_EXEC) && (!res_valid_q || res_pop_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ISSUE: if (pop_o) state_d = ST_EXEC;
      ST_EXEC:  if (exec_go) state_d = ST_ISSUE;
      default:  state_d = ST_ISSUE;
    endcase
  end

  // Execute the held instruction.
  always_comb begin
    src       = ex_item_q.use_mem ? rdata_q : ex_item_q.operand;
    alu       = '0;
    cond      = 1'b0;
    mbyte     = '0;
    mem_we    = 1'b0;
    mem_wdata = acc_q;
    acc_d     = acc_q;
    zero_d    = zero_q;
    carry_d   = carry_q;
    neg_d     = neg_q;
    ip_d      = ip_q;
    halt_d    = halt_q;
    in_range  = ({1'b0, ip_q} + {1'b0, ex_item_q.operand}) < prog_len_q;
    if (ex_item_q.kind == KIND_HOST) begin
      mem_we    = exec_go;
      mem_wdata = ex_item_q.host_data;
      mbyte     = ex_item_q.host_data;
    end else if (!halt_q) begin
      ip_d = ip_q + 8'd1;
      unique case (ex_item_q.kind)
        KIND_NOP: ;
        KIND_LOAD: begin
          acc_d = src;
          mbyte = ex_item_q.use_mem ? rdata_q : 8'd0;
          {zero_d, carry_d, neg_d} = flags_of({1'b0, src});
        end
        KIND_STORE: begin
          mem_we = exec_go;
          mbyte  = acc_q;
          {zero_d, carry_d, neg_d} = flags_of({1'b0, acc_q});
        end
        KIND_ADD, KIND_SUB: begin
          alu = (ex_item_q.kind == KIND_ADD) ? ({1'b0, acc_q} + {1'b0, src})
                                             : ({1'b0, acc_q} - {1'b0, src});
          mbyte = ex_item_q.use_mem ? rdata_q : 8'd0;
          acc_d = alu[7:0];
          {zero_d, carry_d, neg_d} = flags_of(alu);
        end
        KIND_JUMP: begin
          ip_d = ex_item_q.operand;
          {zero_d, carry_d, neg_d} = flags_of({1'b0, acc_q});
        end
        KIND_BRANCH: begin
          unique case (ex_item_q.cond)
            COND_ZERO:  cond = zero_q;
            COND_CARRY: cond = carry_q;
            COND_NEG:   cond = neg_q;
            default:    cond = 1'b0;
          endcase
          if (cond) ip_d = ip_q + ex_item_q.operand;
          {zero_d, carry_d, neg_d} = flags_of({1'b0, acc_q});
        end
        KIND_END: halt_d = 1'b1;
        default:  ip_d = ip_q;
      endcase
    end
    res_d.acc      = acc_d;
    res_d.zero     = zero_d;
    res_d.carry    = carry_d;
    res_d.neg      = neg_d;
    res_d.ptr      = ip_d;
    res_d.in_range = in_range;
    res_d.mbyte    = mbyte;
    res_d.halted   = halt_d;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ISSUE;
      acc_q       <= '0;
      zero_q      <= 1'b0;
      carry_q     <= 1'b0;
      neg_q       <= 1'b0;
      ip_q        <= '0;
      halt_q      <= 1'b0;
      prog_len_q  <= PROG_LEN_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        prog_len_q <= cfg_wdata_i;
      end
      if (exec_go) begin
        acc_q   <= acc_d;
        zero_q  <= zero_d;
        carry_q <= carry_d;
        neg_q   <= neg_d;
        ip_q    <= ip_d;
        halt_q  <= halt_d;
      end
      if (exec_go) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Hold the issued item and the result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_item_q <= head_i.item;
      ex_idx_q  <= rd_idx;
    end
    if (exec_go) begin
      res_q <= res_d;
    end
  end

  // Data memory: read at issue, write at execute.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[ex_idx_q] <= mem_wdata;
    end
    if (pop_o) begin
      rdata_q <= dmem[rd_idx];
    end
  end

  assign res_empty_o       = !res_valid_q;
  assign accumulator_out_o = res_q.acc;
  assign zero_flag_o       = res_q.zero;
  assign carry_flag_o      = res_q.carry;
  assign negative_flag_o   = res_q.neg;
  assign next_pointer_o    = res_q.ptr;
  assign target_in_range_o = res_q.in_range;
  assign memory_byte_o     = res_q.mbyte;
  assign halted_o          = res_q.halted;

  `ACPU_ASSERT(a_halt_sticky, clk_i, rst_ni, !$fell(halt_q), "halted cleared without reset")
  `ACPU_ASSERT(a_halt_freeze, clk_i, rst_ni, halt_q |=> ($stable(ip_q) && $stable(acc_q)), "state moved while halted")
  `ACPU_ASSERT(a_issue_spacing, clk_i, rst_ni, pop_o |=> !pop_o, "issued before previous item executed")

endmodule

// ----- dv/accumulator_cpu_execute_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_test: self-checking bench for the execute block
// Drives instructions through the push/full side and checks every popped
// result against a typed-in expectation or the in-bench model. A directed
// table runs first. Random phases follow at several program lengths and
// traffic patterns, one of them with a long receiver hold-off. A closing
// table halts the machine and checks that only host writes still act.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_test;
  import acpu_pkg::*;

  localparam int LATENCY = 2;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PRINT_LIMIT = 20;
  localparam logic [3:0] CMD_UNDEF_LO = 4'd14;
  localparam logic [3:0] CMD_UNDEF_HI = 4'd15;

  typedef struct packed {
    logic [7:0] acc;
    logic       zero;
    logic       carry;
    logic       neg;
    logic [7:0] ptr;
    logic       in_range;
    logic [7:0] mbyte;
    logic       halted;
  } exec_result_t;

  typedef struct packed {
    logic [3:0]   cmd;
    logic [7:0]   opnd;
    logic [7:0]   hdata;
    logic         typed;
    exec_result_t want;
  } stim_row_t;

  // DUT ports
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [3:0] command_i = CMD_NOP;
  logic [7:0] operand_i = 8'h00;
  logic [7:0] host_data_i = 8'h00;
  logic       cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = PROG_LEN_RESET;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] accumulator_out_o;
  logic       zero_flag_o;
  logic       carry_flag_o;
  logic       negative_flag_o;
  logic [7:0] next_pointer_o;
  logic       target_in_range_o;
  logic [7:0] memory_byte_o;
  logic       halted_o;

  // Machine state as the bench predicts it
  logic [7:0] acc_q;
  logic       zero_q;
  logic       carry_q;
  logic       neg_q;
  logic [7:0] pc_q;
  logic       halt_q;
  logic [8:0] prog_len;
  logic [7:0] data_mem [256];
  bit         mem_written [256];
  logic [7:0] written_addrs [$];

  exec_result_t pending_results [$];

  int error_count = 0;
  int results_checked = 0;
  int instrs_sent = 0;
  int length_settings = 0;
  int input_stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  // Directed rows; expectations typed in assume reset state and length 256
  stim_row_t opening_rows [24] = '{
    '{CMD_NOP,     8'h00, 8'h00, 1'b1, '{8'h00, 0, 0, 0, 8'h01, 1, 8'h00, 0}},
    '{CMD_LDA_IMM, 8'hFF, 8'h00, 1'b1, '{8'hFF, 0, 0, 1, 8'h02, 0, 8'h00, 0}},
    '{CMD_ADD_IMM, 8'h01, 8'h00, 1'b1, '{8'h00, 0, 1, 0, 8'h03, 1, 8'h00, 0}},
    '{CMD_SUB_IMM, 8'h01, 8'h00, 1'b1, '{8'hFF, 0, 1, 1, 8'h04, 1, 8'h00, 0}},
    '{CMD_HOST_WR, 8'hFF, 8'hA5, 1'b1, '{8'hFF, 0, 1, 1, 8'h04, 0, 8'hA5, 0}},
    '{CMD_HOST_WR, 8'h00, 8'h00, 1'b1, '{8'hFF, 0, 1, 1, 8'h04, 1, 8'h00, 0}},
    '{CMD_LDA_MEM, 8'h00, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h05, 1, 8'h00, 0}},
    '{CMD_BRZ,     8'h10, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h15, 1, 8'h00, 0}},
    '{CMD_ADD_MEM, 8'hFF, 8'h00, 1'b1, '{8'hA5, 0, 0, 1, 8'h16, 0, 8'hA5, 0}},
    '{CMD_STA,     8'h80, 8'h00, 1'b1, '{8'hA5, 0, 0, 1, 8'h17, 1, 8'hA5, 0}},
    '{CMD_SUB_MEM, 8'h80, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h18, 1, 8'hA5, 0}},
    '{CMD_BRC,     8'h40, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h19, 1, 8'h00, 0}},
    '{CMD_LDA_IMM, 8'h80, 8'h00, 1'b1, '{8'h80, 0, 0, 1, 8'h1A, 1, 8'h00, 0}},
    '{CMD_BRN,     8'hF0, 8'h00, 1'b1, '{8'h80, 0, 0, 1, 8'h0A, 0, 8'h00, 0}},
    '{CMD_ADD_IMM, 8'h80, 8'h00, 1'b1, '{8'h00, 0, 1, 0, 8'h0B, 1, 8'h00, 0}},
    '{CMD_BRC,     8'h05, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h10, 1, 8'h00, 0}},
    '{CMD_JMP,     8'hFF, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'hFF, 0, 8'h00, 0}},
    '{CMD_NOP,     8'h00, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h00, 1, 8'h00, 0}},
    '{CMD_UNDEF_LO, 8'h33, 8'h00, 1'b0, '0},
    '{CMD_UNDEF_HI, 8'hCC, 8'h5A, 1'b0, '0},
    '{CMD_SUB_IMM, 8'h00, 8'h00, 1'b1, '{8'h00, 1, 0, 0, 8'h01, 1, 8'h00, 0}},
    '{CMD_BRZ,     8'h00, 8'h00, 1'b0, '0},
    '{CMD_BRN,     8'h7F, 8'hFF, 1'b0, '0},
    '{CMD_HOST_WR, 8'h5A, 8'hFF, 1'b1, '{8'h00, 1, 0, 0, 8'h02, 1, 8'hFF, 0}}
  };

  // Closing rows: halt, then show that only host writes still act
  stim_row_t closing_rows [7] = '{
    '{CMD_END,      8'h00, 8'h00, 1'b0, '0},
    '{CMD_LDA_IMM,  8'h12, 8'h34, 1'b0, '0},
    '{CMD_HOST_WR,  8'h3C, 8'hC3, 1'b0, '0},
    '{CMD_LDA_MEM,  8'h80, 8'h00, 1'b0, '0},
    '{CMD_JMP,      8'h40, 8'h00, 1'b0, '0},
    '{CMD_UNDEF_HI, 8'hFF, 8'hFF, 1'b0, '0},
    '{CMD_BRZ,      8'h01, 8'h00, 1'b0, '0}
  };

  accumulator_cpu_execute dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .operand_i         (operand_i),
    .host_data_i       (host_data_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .empty             (empty),
    .pop               (pop),
    .accumulator_out_o (accumulator_out_o),
    .zero_flag_o       (zero_flag_o),
    .carry_flag_o      (carry_flag_o),
    .negative_flag_o   (negative_flag_o),
    .next_pointer_o    (next_pointer_o),
    .target_in_range_o (target_in_range_o),
    .memory_byte_o     (memory_byte_o),
    .halted_o          (halted_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count a mismatch; print only the first few
  task automatic report(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report($sformatf("result %0d: %s is %0h, expected %0h",
                       results_checked, name, got, want));
    end
  endtask

  function automatic void set_flags(input logic [8:0] r);
    zero_q = (r == 9'd0);
    carry_q = r[8];
    neg_q = r[7];
  endfunction

  // Write a data byte and remember the address as safe to read
  function automatic void store_byte(input logic [7:0] addr, input logic [7:0] val);
    data_mem[addr] = val;
    if (!mem_written[addr]) begin
      mem_written[addr] = 1'b1;
      written_addrs.push_back(addr);
    end
  endfunction

  // Execute one instruction on the predicted state and return its result
  function automatic exec_result_t execute_instr(input logic [3:0] cmd,
                                                 input logic [7:0] opnd,
                                                 input logic [7:0] hdata);
    exec_result_t res;
    logic [7:0] ip;
    logic [7:0] next_ip;
    logic [7:0] mbyte;
    logic [7:0] arg;
    logic [8:0] sum;
    logic       cond;
    ip = pc_q;
    next_ip = pc_q;
    mbyte = 8'h00;
    res.in_range = (({1'b0, ip} + {1'b0, opnd}) < prog_len);
    if (cmd == CMD_HOST_WR) begin
      store_byte(opnd, hdata);
      mbyte = hdata;
    end else if (!halt_q) begin
      next_ip = ip + 8'd1;
      case (cmd)
        CMD_NOP: ;
        CMD_LDA_IMM: begin
          acc_q = opnd;
          set_flags({1'b0, opnd});
        end
        CMD_LDA_MEM: begin
          mbyte = data_mem[opnd];
          acc_q = mbyte;
          set_flags({1'b0, mbyte});
        end
        CMD_STA: begin
          store_byte(opnd, acc_q);
          mbyte = acc_q;
          set_flags({1'b0, acc_q});
        end
        CMD_ADD_IMM, CMD_ADD_MEM, CMD_SUB_IMM, CMD_SUB_MEM: begin
          arg = opnd;
          if (cmd == CMD_ADD_MEM || cmd == CMD_SUB_MEM) begin
            mbyte = data_mem[opnd];
            arg = mbyte;
          end
          // 9-bit add or subtract: bit 8 is carry or borrow
          if (cmd == CMD_ADD_IMM || cmd == CMD_ADD_MEM) begin
            sum = {1'b0, acc_q} + {1'b0, arg};
          end else begin
            sum = {1'b0, acc_q} - {1'b0, arg};
          end
          set_flags(sum);
          acc_q = sum[7:0];
        end
        CMD_JMP: begin
          next_ip = opnd;
          set_flags({1'b0, acc_q});
        end
        CMD_BRZ, CMD_BRC, CMD_BRN: begin
          // condition uses the flags from before this instruction
          cond = (cmd == CMD_BRZ) ? zero_q : (cmd == CMD_BRC) ? carry_q : neg_q;
          if (cond) begin
            next_ip = ip + opnd;
          end
          set_flags({1'b0, acc_q});
        end
        CMD_END: halt_q = 1'b1;
        default: next_ip = ip;
      endcase
    end
    pc_q = next_ip;
    res.acc = acc_q;
    res.zero = zero_q;
    res.carry = carry_q;
    res.neg = neg_q;
    res.ptr = pc_q;
    res.mbyte = mbyte;
    res.halted = halt_q;
    return res;
  endfunction

  // Random instruction; memory reads only hit addresses already written
  function automatic void pick_random_instr(output logic [3:0] cmd,
                                            output logic [7:0] opnd,
                                            output logic [7:0] hdata);
    int r;
    logic [7:0] read_addr;
    r = $urandom_range(99);
    hdata = 8'($urandom);
    case ($urandom_range(7))
      0: opnd = 8'h00;
      1: opnd = 8'hFF;
      2: opnd = 8'h80;
      default: opnd = 8'($urandom);
    endcase
    read_addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
    if (r < 8) begin
      cmd = CMD_HOST_WR;
    end else if (r < 18) begin
      cmd = CMD_LDA_IMM;
    end else if (r < 26) begin
      cmd = CMD_LDA_MEM;
      opnd = read_addr;
    end else if (r < 34) begin
      cmd = CMD_STA;
    end else if (r < 44) begin
      cmd = CMD_ADD_IMM;
    end else if (r < 52) begin
      cmd = CMD_ADD_MEM;
      opnd = read_addr;
    end else if (r < 62) begin
      cmd = CMD_SUB_IMM;
    end else if (r < 70) begin
      cmd = CMD_SUB_MEM;
      opnd = read_addr;
    end else if (r < 75) begin
      cmd = CMD_JMP;
    end else if (r < 95) begin
      cmd = 4'($urandom_range(CMD_BRN, CMD_BRZ));
    end else if (r < 98) begin
      cmd = CMD_NOP;
    end else begin
      cmd = ($urandom_range(1) == 0) ? CMD_UNDEF_LO : CMD_UNDEF_HI;
    end
  endfunction

  // Offer one instruction, hold it until the transfer, then predict it
  task automatic send_instr(input stim_row_t row);
    exec_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= row.cmd;
    operand_i <= row.opnd;
    host_data_i <= row.hdata;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    predicted = execute_instr(row.cmd, row.opnd, row.hdata);
    pending_results.push_back(row.typed ? row.want : predicted);
    instrs_sent++;
  endtask

  // Stop sending and wait until every expected result has been popped
  task automatic drain_results();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report($sformatf("%0d expected results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_program_length(input logic [8:0] len);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    prog_len = len;
    length_settings++;
  endtask

  task automatic run_random_phase(input int send_idle, input int recv_stall,
                                  input int hold, input logic [8:0] len,
                                  input int count);
    stim_row_t row;
    drain_results();
    write_program_length(len);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    hold_left = hold;
    row = '0;
    repeat (count) begin
      pick_random_instr(row.cmd, row.opnd, row.hdata);
      send_instr(row);
    end
  endtask

  // Result side: check each transfer, then choose pop for the next cycle
  always @(posedge clk_i) begin
    exec_result_t got;
    exec_result_t want;
    if (rst_ni && push && full) begin
      input_stall_cycles++;
    end
    if (rst_ni && pop && !empty) begin
      got = '{accumulator_out_o, zero_flag_o, carry_flag_o, negative_flag_o,
              next_pointer_o, target_in_range_o, memory_byte_o, halted_o};
      if (pending_results.size() == 0) begin
        report("result popped with nothing expected");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        compare_field("accumulator_out", got.acc, want.acc);
        compare_field("zero_flag", got.zero, want.zero);
        compare_field("carry_flag", got.carry, want.carry);
        compare_field("negative_flag", got.neg, want.neg);
        compare_field("next_pointer", got.ptr, want.ptr);
        compare_field("target_in_range", got.in_range, want.in_range);
        compare_field("memory_byte", got.mbyte, want.mbyte);
        compare_field("halted", got.halted, want.halted);
      end
    end
    // hold off pop for a counted stretch so the block backs up
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Main sequence
  initial begin
    acc_q = 8'h00;
    zero_q = 1'b0;
    carry_q = 1'b0;
    neg_q = 1'b0;
    pc_q = 8'h00;
    halt_q = 1'b0;
    prog_len = PROG_LEN_RESET;
    foreach (mem_written[i]) begin
      mem_written[i] = 1'b0;
      data_mem[i] = 8'h00;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset program length
    foreach (opening_rows[i]) begin
      send_instr(opening_rows[i]);
    end

    // random phases: traffic pattern and program length change per phase
    run_random_phase(0, 0, 0, 9'd1, 160);
    run_random_phase(85, 0, 0, 9'd256, 160);
    run_random_phase(0, 85, 0, 9'($urandom_range(256, 1)), 170);
    run_random_phase(11, 11, 0, 9'($urandom_range(256, 1)), 170);
    run_random_phase(0, 0, 120, 9'($urandom_range(256, 1)), 120);
    run_random_phase(11, 11, 0, 9'($urandom_range(256, 1)), 220);

    // halt the machine and confirm what it still accepts
    drain_results();
    write_program_length(9'($urandom_range(256, 1)));
    foreach (closing_rows[i]) begin
      send_instr(closing_rows[i]);
    end
    drain_results();

    $display("Ran %0d instructions (%0d directed), checked %0d results over %0d lengths",
             instrs_sent, $size(opening_rows) + $size(closing_rows), results_checked,
             length_settings);
    $display("Input held off by full for %0d cycles; %0d data addresses written",
             input_stall_cycles, written_addrs.size());
    if (error_count == 0) begin
      $display("PASS accumulator_cpu_execute");
    end else begin
      $display("FAIL accumulator_cpu_execute");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL accumulator_cpu_execute");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/acpu_pkg.sv
design/acpu_front.sv
design/acpu_back.sv
design/accumulator_cpu_execute.sv
dv/accumulator_cpu_execute_test.sv
